[rtl/core/dccsm_pkg.sv]
package dccsm_pkg;

   // CV store geometry
   localparam int CV_DEPTH  = 1024;
   localparam int CV_AW     = $clog2(CV_DEPTH);
   localparam int CV_ADDR_W = 11;
   localparam logic [CV_AW-1:0]     CV_LAST     = CV_AW'(CV_DEPTH - 1);
   localparam logic [CV_ADDR_W-1:0] CV_ADDR_MAX = CV_ADDR_W'(CV_DEPTH);

   // packet kinds carried in the request sideband
   typedef enum logic [1:0] {
      OP_PAGED      = 2'd0,
      OP_DIRECT     = 2'd1,
      OP_CLEAR_ONCE = 2'd2,
      OP_IGNORE     = 2'd3
   } opcode_type;

   // paged register codes (byte0 bits 2:0, with bit 2 set)
   localparam logic [2:0] REG_CV29 = 3'd4;
   localparam logic [2:0] REG_PAGE = 3'd5;
   localparam logic [2:0] REG_CV7  = 3'd6;
   localparam logic [2:0] REG_CV8  = 3'd7;

   // fixed CV numbers behind the paged fixed registers
   localparam logic [CV_ADDR_W-1:0] CV_NUM_29 = 11'd29;
   localparam logic [CV_ADDR_W-1:0] CV_NUM_7  = 11'd7;
   localparam logic [CV_ADDR_W-1:0] CV_NUM_8  = 11'd8;

   // direct instruction codes (byte0 bits 3:2)
   localparam logic [1:0] DIR_VERIFY = 2'b01;
   localparam logic [1:0] DIR_BIT    = 2'b10;
   localparam logic [1:0] DIR_WRITE  = 2'b11;

   // bit-operation byte: top three bits must all be set
   localparam logic [2:0] BIT_OP_TAG = 3'b111;

   // once-only flag positions
   localparam int ONCE_PAGE   = 0;
   localparam int ONCE_VERIFY = 1;
   localparam int ONCE_WRITE  = 2;

   typedef struct packed {
      opcode_type op;
      logic [7:0] b3;
      logic [7:0] b2;
      logic [7:0] b1;
      logic [7:0] b0;
   } req_item_type;

   typedef struct packed {
      logic             en;
      logic [CV_AW-1:0] idx;
      logic [7:0]       data;
   } cv_wr_type;

   typedef struct packed {
      logic [7:0]           cv_data;
      logic [CV_ADDR_W-1:0] cv_address;
      logic                 cv_write;
      logic                 ack_off;
      logic                 ack_pulse;
   } rsp_item_type;

   // CV number addressed by a packet; 0 where the packet names no CV
   function automatic logic [CV_ADDR_W-1:0] cv_addr(opcode_type op, logic [7:0] b0,
                                                     logic [7:0] b1, logic [7:0] page);
      logic [7:0]           pm1;
      logic [CV_ADDR_W-1:0] a;
      // page 0 wraps to 255 here, which is page 256
      pm1 = page - 8'd1;
      a   = '0;
      case (op)
         OP_PAGED: begin
            if (!b0[2]) begin
               a = {1'b0, pm1, b0[1:0]} + 11'd1;
            end else begin
               case (b0[2:0])
                  REG_CV29: a = CV_NUM_29;
                  REG_CV7:  a = CV_NUM_7;
                  REG_CV8:  a = CV_NUM_8;
                  default:  a = '0;
               endcase
            end
         end
         OP_DIRECT: a = {1'b0, b0[1:0], b1} + 11'd1;
         default:   a = '0;
      endcase
      return a;
   endfunction

   function automatic logic cv_in_range(logic [CV_ADDR_W-1:0] a);
      return (a != '0) && (a <= CV_ADDR_MAX);
   endfunction

endpackage

[rtl/core/dcc_service_mode_programmer.sv]
// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  tdata byte0..byte3, tuser opcode
// rsp_      out  rsp_tvalid/rsp_tready  tdata ack_pulse, ack_off, cv_write, cv_address, cv_data
//
// One item per cycle unless rsp_ stalls or the sweep runs; a result is shown once past the
// decode stage and the output register. Accept issues the CV store read (page register
// forwarded from the item ahead); the decode stage decodes, and on retire writes back and
// commits state, forwarding to a same-entry read. After reset the CV store is swept to zero,
// req_tready low. A stalled rsp_ holds the output register, the decode stage, then req_tready.
module dcc_service_mode_programmer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // byte0[7:0], byte1[15:8], byte2[23:16], byte3[31:24]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // ack_pulse[0], ack_off[1], cv_write[2],
                                    // cv_address[13:3], cv_data[21:14], zero[23:22]
);
   import dccsm_pkg::*;

   req_item_type         s1_item_ff;
   logic                 s1_valid_ff;
   logic [CV_ADDR_W-1:0] s1_addr_ff;
   logic                 s1_range_ff;
   rsp_item_type         rsp_ff;
   logic                 rsp_valid_ff;

   req_item_type         req_item;
   logic                 accept;
   logic                 retire;
   logic                 ram_busy;
   logic [7:0]           rd_data;
   logic [7:0]           page_nx;
   logic [CV_ADDR_W-1:0] req_addr;
   logic [CV_ADDR_W-1:0] req_idx_full;
   cv_wr_type            wr;
   rsp_item_type         result;

   assign req_item.op = opcode_type'(req_tuser);
   assign req_item.b0 = req_tdata[7:0];
   assign req_item.b1 = req_tdata[15:8];
   assign req_item.b2 = req_tdata[23:16];
   assign req_item.b3 = req_tdata[31:24];

   // handshake
   assign retire     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !ram_busy && (!s1_valid_ff || retire);
   assign accept     = req_tvalid && req_tready;

   // CV number for the read, with the page as it stands after the item ahead
   assign req_addr     = cv_addr(req_item.op, req_item.b0, req_item.b1, page_nx);
   assign req_idx_full = req_addr - 11'd1;

   // decode stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (retire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff  <= req_item;
         s1_addr_ff  <= req_addr;
         s1_range_ff <= cv_in_range(req_addr);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (retire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (retire) begin
         rsp_ff <= result;
      end
   end

   dccsm_cv_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_idx  (req_idx_full[CV_AW-1:0]),
      .wr      (wr),
      .rd_data (rd_data),
      .busy    (ram_busy)
   );

   dccsm_exec u_exec (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid_ff),
      .retire   (retire),
      .item     (s1_item_ff),
      .addr     (s1_addr_ff),
      .in_range (s1_range_ff),
      .rd_data  (rd_data),
      .page_nx  (page_nx),
      .wr       (wr),
      .result   (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff};

endmodule

[rtl/core/dccsm_cv_ram.sv]
module dccsm_cv_ram (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [dccsm_pkg::CV_AW-1:0] rd_idx,
   input  dccsm_pkg::cv_wr_type       wr,
   output logic [7:0]                 rd_data,
   output logic                       busy
);
   import dccsm_pkg::*;

   logic [7:0]       mem [CV_DEPTH];
   logic [7:0]       rd_data_ff;
   logic             busy_ff;
   logic [CV_AW-1:0] clr_idx_ff;

   // clearing sweep after reset, one entry a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_idx_ff <= '0;
      end else if (busy_ff) begin
         if (clr_idx_ff == CV_LAST) begin
            busy_ff <= 1'b0;
         end
         clr_idx_ff <= clr_idx_ff + 1'b1;
      end
   end

   // single write port: sweep has priority
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_idx_ff] <= 8'h00;
      end else if (wr.en) begin
         mem[wr.idx] <= wr.data;
      end
   end

   // registered read, write data forwarded on a same-entry collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && !busy_ff && (wr.idx == rd_idx)) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= mem[rd_idx];
         end
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

[rtl/core/dccsm_exec.sv]
module dccsm_exec (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           s1_valid,
   input  logic                           retire,
   input  dccsm_pkg::req_item_type        item,
   input  logic [dccsm_pkg::CV_ADDR_W-1:0] addr,
   input  logic                           in_range,
   input  logic [7:0]                     rd_data,
   output logic [7:0]                     page_nx,
   output dccsm_pkg::cv_wr_type           wr,
   output dccsm_pkg::rsp_item_type        result
);
   import dccsm_pkg::*;

   logic [7:0] last_packet_ff [4];
   logic [7:0] last_packet_in [4];
   logic [7:0] page_ff, page_in;
   logic [2:0] once_ff, once_in;
   logic       acked_ff, acked_in;

   logic                 ack;
   logic                 do_write;
   logic [7:0]           wdata;
   logic [7:0]           cur;
   logic [7:0]           mask;
   logic [CV_ADDR_W-1:0] idx_full;
   logic                 rep3;
   logic                 rep4;

   assign idx_full = addr - 11'd1;
   assign cur      = in_range ? rd_data : 8'h00;
   assign mask     = 8'd1 << item.b2[2:0];
   assign rep3     = (item.b0 == last_packet_ff[0]) && (item.b1 == last_packet_ff[1]) &&
                     (item.b2 == last_packet_ff[2]);
   assign rep4     = rep3 && (item.b3 == last_packet_ff[3]);

   // packet decode and next state
   always_comb begin
      last_packet_in = last_packet_ff;
      page_in        = page_ff;
      once_in        = once_ff;
      acked_in       = acked_ff;
      ack            = 1'b0;
      do_write       = 1'b0;
      wdata          = 8'h00;
      result         = '0;
      if (s1_valid) begin
         case (item.op)
            OP_PAGED: begin
               if (!rep3) begin
                  last_packet_in[0] = item.b0;
                  last_packet_in[1] = item.b1;
                  last_packet_in[2] = item.b2;
                  acked_in          = 1'b0;
               end else if (!item.b0[2]) begin
                  // data register through the page register
                  if (item.b0[3]) begin
                     do_write            = 1'b1;
                     wdata               = item.b1;
                     once_in[ONCE_WRITE] = 1'b1;
                     ack                 = 1'b1;
                  end else if (item.b1 == cur) begin
                     once_in[ONCE_VERIFY] = 1'b1;
                     ack                  = 1'b1;
                  end
               end else if (item.b0[2:0] == REG_PAGE) begin
                  if (!once_ff[ONCE_PAGE]) begin
                     page_in            = item.b1;
                     once_in[ONCE_PAGE] = 1'b1;
                     ack                = 1'b1;
                  end
               end else if (item.b0[3]) begin
                  // fixed register write: stored always, acked once
                  do_write = 1'b1;
                  wdata    = item.b1;
                  if (!once_ff[ONCE_WRITE]) begin
                     once_in[ONCE_WRITE] = 1'b1;
                     ack                 = 1'b1;
                  end
               end else if ((item.b1 == cur) && !once_ff[ONCE_VERIFY]) begin
                  once_in[ONCE_VERIFY] = 1'b1;
                  ack                  = 1'b1;
               end
            end
            OP_DIRECT: begin
               if (!rep4) begin
                  last_packet_in[0] = item.b0;
                  last_packet_in[1] = item.b1;
                  last_packet_in[2] = item.b2;
                  last_packet_in[3] = item.b3;
                  acked_in          = 1'b0;
                  result.ack_off    = 1'b1;
               end else if (!acked_ff) begin
                  case (item.b0[3:2])
                     DIR_BIT: begin
                        if (item.b2[7:5] == BIT_OP_TAG) begin
                           if (item.b2[4]) begin
                              do_write = 1'b1;
                              wdata    = item.b2[3] ? (cur | mask) : (cur & ~mask);
                              ack      = 1'b1;
                           end else if (item.b2[3]) begin
                              ack = ((cur & mask) != 8'h00);
                           end else begin
                              ack = ((cur & mask) == 8'h00);
                           end
                        end
                     end
                     DIR_VERIFY: ack = (item.b2 == cur);
                     DIR_WRITE: begin
                        do_write = 1'b1;
                        wdata    = item.b2;
                        ack      = 1'b1;
                     end
                     default: ack = 1'b0;
                  endcase
               end
            end
            OP_CLEAR_ONCE: once_in = '0;
            default:       once_in = once_ff;
         endcase
      end
      // CV write report, dropped beyond the store
      if (do_write && in_range) begin
         result.cv_write   = 1'b1;
         result.cv_address = addr;
         result.cv_data    = wdata;
      end
      if (ack) begin
         result.ack_pulse = 1'b1;
         acked_in         = 1'b1;
      end
   end

   assign page_nx = page_in;
   assign wr.en   = retire && do_write && in_range;
   assign wr.idx  = idx_full[CV_AW-1:0];
   assign wr.data = wdata;

   // state commit on retire
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            last_packet_ff[i] <= 8'h00;
         end
         page_ff  <= 8'h00;
         once_ff  <= 3'b000;
         acked_ff <= 1'b0;
      end else if (retire) begin
         last_packet_ff <= last_packet_in;
         page_ff        <= page_in;
         once_ff        <= once_in;
         acked_ff       <= acked_in;
      end
   end

endmodule

[rtl/core/dccsm_checker.sv]
module dccsm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   import dccsm_pkg::*;

   // nothing accepted or shown right after reset (store sweep pending)
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !req_tready))
      else $error("activity right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // no CV write means zero address and data
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[2]) |-> (rsp_tdata[23:3] == '0))
      else $error("address or data without a CV write");

   // a CV write names a CV inside the store
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2]) |->
         ((rsp_tdata[13:3] != '0) && (rsp_tdata[13:3] <= CV_ADDR_MAX)))
      else $error("CV write outside the store");

   // a new packet neither acks nor writes
   a_off_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1]) |-> (!rsp_tdata[0] && !rsp_tdata[2]))
      else $error("ack-off together with ack or write");

endmodule

bind dcc_service_mode_programmer dccsm_checker u_dccsm_checker (.*);
